@@ hw/rtl/asjq_pkg.sv @@
// Shared types and constants for the arrival-sorted job queue.
`timescale 1ns / 1ps
`default_nettype none

package asjq_pkg;

   localparam int DEFAULT_DEPTH = 16;
   localparam int TDATA_W       = 48;
   localparam int TUSER_W       = 2;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_LIST   = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   // One table entry, laid out as it travels on tdata (user tag in the low byte).
   typedef struct packed {
      logic [15:0] duration;
      logic [15:0] arrival;
      logic [7:0]  job;
      logic [7:0]  user;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS,
      S_INS_HEAD,
      S_REM,
      S_LIST,
      S_RESP
   } state_type;

endpackage

`default_nettype wire

@@ hw/rtl/arrival_sorted_job_queue_top.sv @@
// Top level of the arrival-sorted job queue: request sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  tdata (low bit up)                           tuser / tlast
// req_*     in         user_tag[7:0] job_id[7:0] arrival_time[15:0]  tuser: req_type[1:0]
//                      duration[15:0]
// rsp_*     out        out_user[7:0] out_job[7:0] out_arrival[15:0]  tuser: status[1:0]
//                      out_duration[15:0]                            tlast: last
//
// The entries live in one RAM with a single read and a single write port, and the
// sequencer walks it one entry per cycle while no stalled result channel holds a list.
// An insert into a table that holds entries walks down every entry with a later arrival
// time; an insert into an empty or a full table and a clear do not walk the table.
// A remove walks every entry, and a list reads out every entry.
// Reset zeroes the entry count, the state and the result valid; the RAM is not cleared,
// since no slot at or above the count is read.
// A stalled result channel holds the sequencer only when a new result must be
// loaded into the output register; a new request is taken while a result waits.

module arrival_sorted_job_queue_top #(
   parameter int DEPTH = asjq_pkg::DEFAULT_DEPTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // user_tag[7:0], job_id[15:8], arrival_time[31:16], duration[47:32]
   input  wire logic [asjq_pkg::TDATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  wire logic [asjq_pkg::TUSER_W-1:0] req_tuser,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // out_user[7:0], out_job[15:8], out_arrival[31:16], out_duration[47:32]
   output logic [asjq_pkg::TDATA_W-1:0]      rsp_tdata,
   // status[1:0]
   output logic [asjq_pkg::TUSER_W-1:0]      rsp_tuser,
   output logic                              rsp_tlast
);
   import asjq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   state_type      state_ff, state_in;
   logic [AW-1:0]  idx_ff, idx_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           found_ff, found_in;
   entry_type      new_ff, new_in;
   status_type     res_status_ff, res_status_in;

   logic           rsp_valid_ff, rsp_valid_in;
   entry_type      rsp_data_ff, rsp_data_in;
   status_type     rsp_status_ff, rsp_status_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           rd_en;
   logic [AW-1:0]  rd_addr;
   entry_type      rd_data;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   entry_type      wr_data;

   logic [CW-1:0]  count_m1;
   logic [AW-1:0]  last_idx;
   logic           at_last;
   logic           out_free;
   logic           found_now;
   entry_type      req_entry;

   asjq_entry_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_entry  = entry_type'(req_tdata);
   assign count_m1   = count_ff - CW'(1);
   assign last_idx   = count_m1[AW-1:0];
   assign at_last    = (idx_ff == last_idx);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign found_now  = found_ff || (rd_data.job == new_ff.job);
   assign req_tready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      found_ff      <= found_in;
      new_ff        <= new_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      found_in      = found_ff;
      new_in        = new_ff;
      res_status_in = res_status_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      rd_en   = 1'b0;
      rd_addr = idx_ff;
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               new_in = req_entry;
               unique case (req_kind_type'(req_tuser))
                  REQ_INSERT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        res_status_in = ST_FULL;
                        state_in      = S_RESP;
                     end else if (count_ff == '0) begin
                        wr_en         = 1'b1;
                        wr_addr       = '0;
                        wr_data       = req_entry;
                        count_in      = count_ff + CW'(1);
                        res_status_in = ST_OK;
                        state_in      = S_RESP;
                     end else begin
                        // Walk down from the newest slot, moving later arrivals up.
                        rd_en    = 1'b1;
                        rd_addr  = last_idx;
                        idx_in   = last_idx;
                        state_in = S_INS;
                     end
                  end
                  REQ_REMOVE: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_NOT_FOUND;
                        state_in      = S_RESP;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        idx_in   = '0;
                        found_in = 1'b0;
                        state_in = S_REM;
                     end
                  end
                  REQ_LIST: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                        state_in      = S_RESP;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        idx_in   = '0;
                        state_in = S_LIST;
                     end
                  end
                  REQ_CLEAR: begin
                     count_in      = '0;
                     res_status_in = ST_OK;
                     state_in      = S_RESP;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_INS: begin
            if (new_ff.arrival < rd_data.arrival) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff + AW'(1);
               wr_data = rd_data;
               if (idx_ff == '0) begin
                  state_in = S_INS_HEAD;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff - AW'(1);
                  idx_in  = idx_ff - AW'(1);
               end
            end else begin
               // Equal or earlier arrival stays ahead, so the new entry goes just above it.
               wr_en         = 1'b1;
               wr_addr       = idx_ff + AW'(1);
               wr_data       = new_ff;
               count_in      = count_ff + CW'(1);
               res_status_in = ST_OK;
               state_in      = S_RESP;
            end
         end

         S_INS_HEAD: begin
            wr_en         = 1'b1;
            wr_addr       = '0;
            wr_data       = new_ff;
            count_in      = count_ff + CW'(1);
            res_status_in = ST_OK;
            state_in      = S_RESP;
         end

         S_REM: begin
            // Once the first match is seen, every later entry moves down one slot.
            if (found_ff) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff - AW'(1);
               wr_data = rd_data;
            end
            found_in = found_now;
            if (at_last) begin
               if (found_now) begin
                  count_in      = count_ff - CW'(1);
                  res_status_in = ST_OK;
               end else begin
                  res_status_in = ST_NOT_FOUND;
               end
               state_in = S_RESP;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + AW'(1);
               idx_in  = idx_ff + AW'(1);
            end
         end

         S_LIST: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = rd_data;
               rsp_status_in = ST_OK;
               rsp_last_in   = at_last;
               if (at_last) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + AW'(1);
                  idx_in  = idx_ff + AW'(1);
               end
            end
         end

         S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_status_in = res_status_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

@@ hw/rtl/asjq_entry_ram.sv @@
// Entry table RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module asjq_entry_ram #(
   parameter int DEPTH = asjq_pkg::DEFAULT_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire asjq_pkg::entry_type      wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output asjq_pkg::entry_type           rd_data
);
   import asjq_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read, so a stalled consumer sees it stay.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
